// ===== design/rbd_pkg.sv =====
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int DEPTH    = 256;
  localparam int WORD_W   = 32;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int POS_W    = 9;
  localparam int COUNT_W  = 9;
  localparam int VALUE_W  = 32;
  // Wide enough for a signed position plus the element count without overflow.
  localparam int IDX_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_GET        = 3'd4,
    CMD_SET        = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             is_read;
    status_e          status;
    logic [CNT_W-1:0] count;
  } rsp_t;

endpackage

// ===== design/rbd_ram.sv =====
`timescale 1ns / 1ps

module rbd_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read, so a stalled result keeps its word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rbd_ctrl.sv =====
`timescale 1ns / 1ps

module rbd_ctrl import rbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [2:0]         cmd_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [WORD_W-1:0]  value_i,
  output mem_req_t           mem_req_o,
  output rsp_t               rsp_o
);

  logic [ADDR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              full;
  logic              empty;
  logic              neg;
  logic [IDX_W-1:0]  pos_ext;
  logic [IDX_W-1:0]  cnt_ext;
  logic [IDX_W-1:0]  adj;
  logic              in_range;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] tail_slot;
  logic [ADDR_W-1:0] last_slot;

  assign full      = cnt_q[CNT_W-1];
  assign empty     = (cnt_q == '0);
  assign neg       = position_i[POS_W-1];
  assign pos_ext   = IDX_W'($signed(position_i));
  assign cnt_ext   = IDX_W'(cnt_q);
  // A negative position counts back from the tail.
  assign adj       = neg ? (pos_ext + cnt_ext) : pos_ext;
  assign in_range  = !adj[IDX_W-1] && (adj < cnt_ext);
  assign slot      = head_q + adj[ADDR_W-1:0];
  assign tail_slot = head_q + cnt_q[ADDR_W-1:0];
  assign last_slot = tail_slot - ADDR_W'(1);

  always_comb begin
    head_d          = head_q;
    cnt_d           = cnt_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = slot;
    mem_req_o.wdata = value_i;
    rsp_o.is_read   = 1'b0;
    rsp_o.status    = ST_OK;
    case (cmd_i)
      CMD_PUSH_FRONT: begin
        if (full) begin
          rsp_o.status = ST_FULL;
        end else begin
          head_d         = head_q - ADDR_W'(1);
          mem_req_o.we   = accept_i;
          mem_req_o.addr = head_q - ADDR_W'(1);
          cnt_d          = cnt_q + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          rsp_o.status = ST_FULL;
        end else begin
          mem_req_o.we   = accept_i;
          mem_req_o.addr = tail_slot;
          cnt_d          = cnt_q + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          rsp_o.status = ST_EMPTY;
        end else begin
          mem_req_o.re   = accept_i;
          mem_req_o.addr = head_q;
          rsp_o.is_read  = 1'b1;
          head_d         = head_q + ADDR_W'(1);
          cnt_d          = cnt_q - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          rsp_o.status = ST_EMPTY;
        end else begin
          mem_req_o.re   = accept_i;
          mem_req_o.addr = last_slot;
          rsp_o.is_read  = 1'b1;
          cnt_d          = cnt_q - CNT_W'(1);
        end
      end
      CMD_GET: begin
        if (!in_range) begin
          rsp_o.status = ST_EMPTY;
        end else begin
          mem_req_o.re  = accept_i;
          rsp_o.is_read = 1'b1;
        end
      end
      CMD_SET: begin
        if (!in_range) begin
          rsp_o.status = ST_EMPTY;
        end else begin
          mem_req_o.we = accept_i;
        end
      end
      default: begin
        rsp_o.status = ST_EMPTY;
      end
    endcase
    rsp_o.count = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== design/ring_buffer_deque.sv =====
`timescale 1ns / 1ps

// Double-ended queue of DEPTH words held in a circular single-port memory with a
// head pointer and an element count. Each request pushes or pops at either end,
// or reads or overwrites the element at a logical position (a negative position
// counts back from the tail), and returns exactly one result: the word read, a
// status (ok, empty or out of range, full) and the length after the request.
// A push into a full queue stores nothing and reports full. One request is
// taken every clock cycle when the output side keeps up. The memory is read at
// the edge that takes a request, and the word moves into the output register
// when the memory stage advances, so a result passes through the memory stage
// and the output register before the receiver can take it.
// A write is complete before the next request's read, so back-to-back requests
// to the same slot need no forwarding. There is no clearing pass after reset:
// only held slots are read.

module ring_buffer_deque import rbd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          cmd_i,
  input  logic signed [POS_W-1:0] position_i,
  input  logic [VALUE_W-1:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VALUE_W-1:0]  result_value_o,
  output logic [1:0]          status_o,
  output logic [COUNT_W-1:0]  count_after_o
);

  logic              accept;
  logic              adv_p;
  mem_req_t          mem_req;
  rsp_t              rsp;
  logic [WORD_W-1:0] rdata;

  // Memory stage: holds the request whose read data is coming out of the RAM.
  logic              p_valid_q, p_valid_d;
  rsp_t              p_rsp_q;

  // Output register.
  logic               o_valid_q, o_valid_d;
  logic [WORD_W-1:0]  o_value_q;
  status_e            o_status_q;
  logic [CNT_W-1:0]   o_count_q;

  // The memory stage moves on when the output register is empty or is being
  // emptied; a new request is taken whenever the memory stage has room.
  assign adv_p      = p_valid_q && (!o_valid_q || !out_stall_i);
  assign in_stall_o = p_valid_q && !adv_p;
  assign accept     = in_valid_i && !in_stall_o;

  rbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .position_i (position_i),
    .value_i    (WORD_W'(value_i)),
    .mem_req_o  (mem_req),
    .rsp_o      (rsp)
  );

  rbd_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    p_valid_d = p_valid_q;
    if (accept) begin
      p_valid_d = 1'b1;
    end else if (adv_p) begin
      p_valid_d = 1'b0;
    end
    o_valid_d = o_valid_q;
    if (adv_p) begin
      o_valid_d = 1'b1;
    end else if (o_valid_q && !out_stall_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_rsp_q <= rsp;
    end
    if (adv_p) begin
      // Only a successful read returns a word; every other result carries zero.
      o_value_q  <= p_rsp_q.is_read ? rdata : '0;
      o_status_q <= p_rsp_q.status;
      o_count_q  <= p_rsp_q.count;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign result_value_o = VALUE_W'(o_value_q);
  assign status_o       = o_status_q;
  assign count_after_o  = COUNT_W'(o_count_q);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (o_count_q <= CNT_W'(DEPTH)))
    else $error("count_after beyond capacity");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (o_status_q != ST_OK)) |-> (o_value_q == '0))
    else $error("non-zero word on a failed request");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> p_valid_q)
    else $error("accepted request lost before the memory stage");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (o_valid_q && out_stall_i && p_valid_q))
    else $error("input stalled without back-pressure");

  a_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("read and write issued together");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Both channels use valid/stall. The driver and the receiver move their signals on the
// falling edge. The monitor samples on the rising edge, so no check depends on the
// order of events within a time step.

module testbench;
  import rbd_pkg::*;

  // Command codes that the package leaves unnamed. The block must ignore them and
  // report the empty status.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // The long receiver hold-off, in cycles. It is well beyond what the pipeline can
  // buffer, so the block must stall its input.
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [2:0]              cmd;
    logic signed [POS_W-1:0] pos;
    logic [VALUE_W-1:0]      value;
  } deque_req_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } deque_rsp_t;

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [2:0]                cmd_i = '0;
  logic signed [POS_W-1:0]   position_i = '0;
  logic [VALUE_W-1:0]        value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [VALUE_W-1:0]        result_value_o;
  logic [1:0]                status_o;
  logic [COUNT_W-1:0]        count_after_o;

  ring_buffer_deque i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .count_after_o  (count_after_o)
  );

  // Requests that wait for the driver, and the replies that the shadow deque
  // predicts, oldest first.
  deque_req_t pending_requests[$];
  deque_rsp_t awaited_replies[$];

  // The shadow copy of the deque: the slot store, the physical slot of the front
  // element, and the number of elements held.
  logic [WORD_W-1:0] shadow_slots [DEPTH];
  logic [ADDR_W-1:0] shadow_front = '0;
  logic [CNT_W-1:0]  shadow_count = '0;

  // Occupancy as seen by the stimulus generator. It runs ahead of the block, and
  // it is used only to aim get and set positions at held elements.
  int   queued_count = 0;
  int   error_count = 0;
  logic gaps_on = 1'b1;
  int   hold_requests = 0;
  int   holds_started = 0;
  int   hold_left = 0;
  logic req_taken = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // This applies one accepted request to the shadow deque and returns the reply the
  // block owes for it. A negative position is first rebased on the current count.
  // Any request that fails leaves the state alone and returns a zero word.
  function automatic deque_rsp_t apply_to_shadow_deque(input deque_req_t req);
    deque_rsp_t rsp;
    int         idx;
    logic       in_range;

    rsp.value  = '0;
    rsp.status = ST_OK;
    idx = int'(req.pos);
    if (idx < 0) idx = idx + int'(shadow_count);
    in_range = (idx >= 0) && (idx < int'(shadow_count));

    case (req.cmd)
      CMD_PUSH_FRONT: begin
        if (shadow_count == DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_front = shadow_front - 1'b1;
          shadow_slots[shadow_front] = req.value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_slots[shadow_front + ADDR_W'(shadow_count)] = req.value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.value = shadow_slots[shadow_front];
          shadow_front = shadow_front + 1'b1;
          shadow_count = shadow_count - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          shadow_count = shadow_count - 1'b1;
          rsp.value = shadow_slots[shadow_front + ADDR_W'(shadow_count)];
        end
      end
      CMD_GET: begin
        if (!in_range) rsp.status = ST_EMPTY;
        else rsp.value = shadow_slots[shadow_front + ADDR_W'(idx)];
      end
      CMD_SET: begin
        if (!in_range) rsp.status = ST_EMPTY;
        else shadow_slots[shadow_front + ADDR_W'(idx)] = req.value;
      end
      default: begin
        rsp.status = ST_EMPTY;
      end
    endcase

    if (rsp.status != ST_OK) rsp.value = '0;
    rsp.count = COUNT_W'(shadow_count);
    return rsp;
  endfunction

  // This queues one request for the driver and keeps the generator's view of the
  // occupancy up to date.
  task automatic queue_request(input logic [2:0] cmd, input int pos,
                               input logic [VALUE_W-1:0] value);
    deque_req_t req;
    req.cmd   = cmd;
    req.pos   = POS_W'(pos);
    req.value = value;
    pending_requests.push_back(req);
    if ((cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) && queued_count < DEPTH)
      queued_count++;
    else if ((cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) && queued_count > 0)
      queued_count--;
  endtask

  // This queues a run of random requests. The push and pop shares steer the
  // occupancy toward full or empty. The remainder is mostly get and set, with a few
  // spare codes. Most get and set positions hit a held element, and half of those
  // are written in the negative form that counts back from the tail.
  task automatic queue_random(input int num, input int push_pct, input int pop_pct);
    int               roll;
    int               pos;
    logic [2:0]       cmd;
    logic [VALUE_W-1:0] value;
    repeat (num) begin
      roll = $urandom_range(99);
      if (roll < 2)
        cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
      else if (roll < 2 + push_pct)
        cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else if (roll < 2 + push_pct + pop_pct)
        cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      else
        cmd = $urandom_range(1) ? CMD_SET : CMD_GET;

      if ((cmd == CMD_GET || cmd == CMD_SET) && queued_count > 0 &&
          $urandom_range(99) < 80) begin
        pos = $urandom_range(queued_count - 1);
        if ($urandom_range(1)) pos = pos - queued_count;
      end else begin
        pos = int'($signed(POS_W'($urandom)));
      end

      case ($urandom_range(15))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      queue_request(cmd, pos, value);
    end
  endtask

  // Driver. A new request is taken from the queue only once the current one has been
  // accepted, or when nothing is being offered, so a stalled request stays steady.
  always @(negedge clk_i) begin
    deque_req_t issued;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (pending_requests.size() != 0 && !(gaps_on && $urandom_range(99) < 19)) begin
        issued = pending_requests.pop_front();
        in_valid_i <= 1'b1;
        cmd_i      <= issued.cmd;
        position_i <= issued.pos;
        value_i    <= issued.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver. It stalls at random while gaps are on. When the stimulus asks for a
  // hold-off, it keeps stall high while a countdown loaded from HOLD_CYCLES runs out.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_started != hold_requests) begin
      holds_started <= holds_started + 1;
      hold_left     <= HOLD_CYCLES;
      out_stall_i   <= 1'b1;
    end else begin
      out_stall_i <= gaps_on && ($urandom_range(99) < 19);
    end
  end

  // Monitor. An accepted request is predicted at once. Each accepted reply is
  // checked against the oldest prediction.
  always @(posedge clk_i) begin
    deque_req_t seen;
    deque_rsp_t want;
    if (rst_ni) begin
      req_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        seen.cmd   = cmd_i;
        seen.pos   = position_i;
        seen.value = value_i;
        awaited_replies.push_back(apply_to_shadow_deque(seen));
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited_replies.size() == 0) begin
          $error("reply with no request outstanding: value %h status %0d count %0d",
                 result_value_o, status_o, count_after_o);
          error_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (result_value_o !== want.value) begin
            $error("result_value: expected %h, got %h", want.value, result_value_o);
            error_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
          if (count_after_o !== want.count) begin
            $error("count_after: expected %0d, got %0d", want.count, count_after_o);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. It covers pops and lookups on an empty deque, the extremes of
    // position and value, a push at the front that wraps the head below slot zero,
    // get and set from both ends, out-of-range positions, the spare codes, and a
    // drain back to empty.
    queue_request(CMD_POP_FRONT, 0, '1);
    queue_request(CMD_POP_BACK, -1, '0);
    queue_request(CMD_GET, 0, '0);
    queue_request(CMD_SET, -1, 32'h1234_5678);
    queue_request(CMD_PUSH_BACK, 0, '1);
    queue_request(CMD_PUSH_FRONT, 0, '0);
    queue_request(CMD_PUSH_BACK, 0, 32'hA5A5_A5A5);
    queue_request(CMD_GET, -256, '0);
    queue_request(CMD_GET, 255, '0);
    queue_request(CMD_GET, -1, '0);
    queue_request(CMD_GET, -3, '0);
    queue_request(CMD_GET, 2, '0);
    queue_request(CMD_SET, 1, 32'h5A5A_5A5A);
    queue_request(CMD_SET, -4, '1);
    queue_request(CMD_SET, 3, '1);
    queue_request(CMD_GET, 1, '0);
    queue_request(CMD_SPARE_6, -256, '1);
    queue_request(CMD_SPARE_7, 255, '1);
    queue_request(CMD_POP_FRONT, 0, '0);
    queue_request(CMD_POP_BACK, 0, '0);
    queue_request(CMD_POP_FRONT, 0, '0);
    queue_request(CMD_POP_BACK, 0, '0);
    queue_request(CMD_GET, -1, '0);

    // Fill until the deque is full and pushes bounce. Partway in, the receiver holds
    // off for a long stretch while the driver keeps offering requests.
    queue_random(350, 75, 5);
    while (pending_requests.size() > 200) @(posedge clk_i);
    hold_requests = hold_requests + 1;
    queue_random(350, 5, 75);

    // Mixed traffic at full rate on both sides.
    while (pending_requests.size() != 0) @(posedge clk_i);
    gaps_on = 1'b0;
    queue_random(400, 35, 30);
    while (pending_requests.size() != 0) @(posedge clk_i);
    gaps_on = 1'b1;

    // A second fill and drain with mixed traffic in between.
    queue_random(300, 80, 5);
    queue_random(250, 35, 35);
    queue_random(300, 5, 80);

    while (pending_requests.size() != 0 || in_valid_i) @(posedge clk_i);
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog. A correct run needs some tens of microseconds.
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
